@@ src/atsi_pkg.sv @@
// ----------------------------------------------------------------------------
// atsi_pkg
// Shared types and constants for the table search and interpolation block.
// ----------------------------------------------------------------------------
package atsi_pkg;

    localparam int ENTRY_W   = 15;
    localparam int INDEX_W   = 11;
    localparam int TEMP_W    = 20;
    localparam int FLAG_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int QUO_BITS  = 7;
    localparam int REM_W     = 22;
    localparam int DEG_W     = 13;

    localparam int CENTI_PER_DEG = 100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_CELSIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_HIGH  = 2'd2;

    // register reset values (-200 degrees, full index range)
    localparam logic [INDEX_W-1:0] BASE_RESET = 11'h738;
    localparam logic [INDEX_W-1:0] LOW_RESET  = 11'd0;
    localparam logic [INDEX_W-1:0] HIGH_RESET = 11'd2047;

    // item kinds
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

    // result flags
    localparam logic [FLAG_W-1:0] LIMIT_NONE = 2'd0;
    localparam logic [FLAG_W-1:0] LIMIT_LOW  = 2'd1;
    localparam logic [FLAG_W-1:0] LIMIT_HIGH = 2'd2;

    // input word layout, lowest field last
    typedef struct packed {
        logic [6:0]         pad;
        logic [ENTRY_W-1:0] adc_code;
        logic [ENTRY_W-1:0] entry_value;
        logic [INDEX_W-1:0] entry_index;
    } s_word_t;

endpackage

@@ src/adc_table_search_interpolate.sv @@
// ----------------------------------------------------------------------------
// adc_table_search_interpolate
// Converts a 15-bit RTD converter code to hundredths of a degree Celsius by
// binary search over a code table and linear interpolation.
// ----------------------------------------------------------------------------
// A load word (tuser 0) writes one table entry; a load to an index at or
// above TABLE_DEPTH is dropped. A convert word (tuser 1) searches the table
// between the low and high index registers for the first entry not below
// the code, then returns a bound temperature with a flag, returns the
// degree of an exact hit or clamp, or interpolates between the found entry
// and the one before it, truncating the hundredths. Timing of a convert
// word is set by the single read port of the table memory and by one shared
// subtractor: each search probe sets the address, then compares on
// registered data. A bound hit then goes to the output state; an exact hit
// or clamp first reads the found entry and the one below it; an
// interpolation also forms numerator and denominator and runs a 7-step
// restoring divide. The input side is held off for the whole conversion;
// the result sits in an output register, so a new word can be taken while
// the previous result still waits on the result side. The table has no
// reset: entries read before they are written give arbitrary results. The
// user must write registers through the cfg channel only while the block is
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module adc_table_search_interpolate
    import atsi_pkg::*;
#(
    parameter int TABLE_DEPTH = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [INDEX_W-1:0]   cfg_data,

    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // entry_index[10:0], entry_value[25:11],
                                   // adc_code[40:26], zero pad
    input  logic        s_tuser,   // mode

    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // temp_centi[19:0], zero pad
    output logic [1:0]  m_tuser    // limit_flag
);

    // table address width and index reduction constants
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int unsigned WRAP_IDX_U = 32'hFFFF_FFFF % TABLE_DEPTH;
    localparam logic [11:0] WRAP_IDX = 12'(WRAP_IDX_U);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;   // read at probe during search
    localparam logic [3:0] S_CMP  = 4'd2;   // compare and narrow the range
    localparam logic [3:0] S_CHK  = 4'd3;   // check probe against the bounds
    localparam logic [3:0] S_RDE  = 4'd4;   // read found entry
    localparam logic [3:0] S_RDB  = 4'd5;   // read entry below
    localparam logic [3:0] S_EVAL = 4'd6;   // pick exact, clamp or interpolate
    localparam logic [3:0] S_DEN  = 4'd7;   // denominator and scaled numerator
    localparam logic [3:0] S_DIV  = 4'd8;   // one quotient bit per cycle
    localparam logic [3:0] S_OUT  = 4'd9;   // hand result to output register

    // index modulo table depth, only the subtract steps that can apply
    function automatic logic [11:0] mod_depth(input logic [INDEX_W-1:0] v);
        logic [11:0] r;
        r = {1'b0, v};
        for (int k = 10; k >= 0; k--) begin
            if ((TABLE_DEPTH << k) <= 2047) begin
                if (r >= 12'(TABLE_DEPTH << k)) begin
                    r = r - 12'(TABLE_DEPTH << k);
                end
            end
        end
        return r;
    endfunction

    s_word_t in_word;
    assign in_word = s_word_t'(s_tdata);

    // state and registers
    logic [3:0]         state_reg, state_next;
    logic [INDEX_W-1:0] base_reg, base_next;
    logic [INDEX_W-1:0] low_reg, low_next;
    logic [INDEX_W-1:0] high_reg, high_next;
    logic [ENTRY_W-1:0] code_reg, code_next;
    logic [11:0]        lo_reg, lo_next;
    logic [11:0]        hi_reg, hi_next;
    logic [INDEX_W-1:0] probe_reg, probe_next;
    logic               eq_reg, eq_next;
    logic               gt_reg, gt_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [ENTRY_W-1:0] below_reg, below_next;
    logic [ENTRY_W-1:0] num_reg, num_next;
    logic [ENTRY_W-1:0] den_reg, den_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [QUO_BITS-2:0] q_reg, q_next;
    logic [2:0]         step_reg, step_next;
    logic [DEG_W-1:0]   deg_reg, deg_next;
    logic [QUO_BITS-1:0] frac_reg, frac_next;
    logic [FLAG_W-1:0]  flag_reg, flag_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [23:0]        m_tdata_reg, m_tdata_next;
    logic [1:0]         m_tuser_reg, m_tuser_next;

    // table memory
    logic [ENTRY_W-1:0] code_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [11:0]        rd_idx;
    logic [INDEX_W-1:0] probe_m1;

    logic s_accept;
    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // loads write straight from the input word
    assign mem_we    = s_accept && (s_tuser == MODE_LOAD)
                       && (32'(in_word.entry_index) < TABLE_DEPTH);
    assign mem_waddr = AW'(in_word.entry_index);

    // read address: probe, or the entry below it (index zero wraps)
    assign probe_m1 = probe_reg - 11'd1;
    always_comb begin
        if (state_reg == S_RDB) begin
            rd_idx = (probe_reg == '0) ? WRAP_IDX : mod_depth(probe_m1);
        end else begin
            rd_idx = mod_depth(probe_reg);
        end
    end
    assign mem_raddr = AW'(rd_idx);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            code_mem[mem_waddr] <= in_word.entry_value;
        end
        rdata_reg <= code_mem[mem_raddr];
    end

    // shared subtractor: search compares, differences and divide steps
    logic [REM_W-1:0] sub_a, sub_b;
    logic [REM_W:0]   sub_res;
    logic             sub_borrow, sub_zero;

    always_comb begin
        case (state_reg)
            S_DEN: begin
                sub_a = REM_W'(entry_reg);
                sub_b = REM_W'(below_reg);
            end
            S_DIV: begin
                sub_a = rem_reg;
                sub_b = REM_W'(den_reg) << step_reg;
            end
            default: begin
                sub_a = REM_W'(code_reg);
                sub_b = REM_W'(rdata_reg);
            end
        endcase
    end
    assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_res[REM_W];
    assign sub_zero   = (sub_res[REM_W-1:0] == '0);

    // range update of one search step
    logic [11:0] cmp_lo, cmp_hi;
    logic [12:0] iter_sum;
    logic [11:0] start_sum;
    assign cmp_lo    = sub_borrow ? lo_reg : (12'(probe_reg) + 12'd1);
    assign cmp_hi    = sub_borrow ? {1'b0, probe_reg} : hi_reg;
    assign iter_sum  = {1'b0, cmp_lo} + {1'b0, cmp_hi};
    assign start_sum = {1'b0, low_reg} + {1'b0, high_reg};

    // whole degree of a chosen index
    logic [INDEX_W-1:0] deg_idx;
    logic               deg_dec;
    logic [DEG_W-1:0]   deg_val;
    assign deg_val = {{2{base_reg[INDEX_W-1]}}, base_reg} + {2'b00, deg_idx}
                     - {12'd0, deg_dec};

    // final temperature from degree and hundredths
    logic [TEMP_W-1:0] temp_calc;
    assign temp_calc = {{7{deg_reg[DEG_W-1]}}, deg_reg} * TEMP_W'(CENTI_PER_DEG)
                       + {13'd0, frac_reg};

    always_comb begin
        state_next    = state_reg;
        base_next     = base_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        code_next     = code_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        probe_next    = probe_reg;
        eq_next       = eq_reg;
        gt_next       = gt_reg;
        entry_next    = entry_reg;
        below_next    = below_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        step_next     = step_reg;
        deg_next      = deg_reg;
        frac_next     = frac_reg;
        flag_next     = flag_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        deg_idx       = probe_reg;
        deg_dec       = 1'b0;

        // register writes, which the user must keep to idle; the block does not enforce it
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_BASE_CELSIUS: base_next = cfg_data;
                CFG_SEARCH_LOW:   low_next  = cfg_data;
                CFG_SEARCH_HIGH:  high_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept && (s_tuser == MODE_CONVERT)) begin
                    code_next  = in_word.adc_code;
                    lo_next    = {1'b0, low_reg};
                    hi_next    = {1'b0, high_reg};
                    probe_next = start_sum[11:1];
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (sub_zero) begin
                    state_next = S_CHK;
                end else begin
                    lo_next    = cmp_lo;
                    hi_next    = cmp_hi;
                    probe_next = 11'(iter_sum >> 1);
                    state_next = (cmp_lo < cmp_hi) ? S_RD : S_CHK;
                end
            end
            S_CHK: begin
                frac_next = '0;
                if (probe_reg == low_reg) begin
                    deg_idx    = low_reg;
                    deg_next   = deg_val;
                    flag_next  = LIMIT_LOW;
                    state_next = S_OUT;
                end else if (probe_reg == high_reg) begin
                    deg_idx    = high_reg;
                    deg_next   = deg_val;
                    flag_next  = LIMIT_HIGH;
                    state_next = S_OUT;
                end else begin
                    state_next = S_RDE;
                end
            end
            S_RDE: begin
                state_next = S_RDB;
            end
            S_RDB: begin
                entry_next = rdata_reg;
                eq_next    = sub_zero;
                gt_next    = !sub_borrow && !sub_zero;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                frac_next = '0;
                flag_next = LIMIT_NONE;
                if (eq_reg) begin
                    deg_next   = deg_val;
                    state_next = S_OUT;
                end else if (gt_reg) begin
                    deg_idx    = high_reg;
                    deg_next   = deg_val;
                    flag_next  = LIMIT_HIGH;
                    state_next = S_OUT;
                end else begin
                    deg_dec  = 1'b1;
                    deg_next = deg_val;
                    if (sub_borrow) begin
                        // code below the lower neighbor, no hundredths
                        state_next = S_OUT;
                    end else begin
                        num_next   = sub_res[ENTRY_W-1:0];
                        below_next = rdata_reg;
                        state_next = S_DEN;
                    end
                end
            end
            S_DEN: begin
                den_next   = sub_res[ENTRY_W-1:0];
                rem_next   = REM_W'(num_reg) * REM_W'(CENTI_PER_DEG);
                q_next     = '0;
                step_next  = 3'(QUO_BITS - 1);
                state_next = S_DIV;
            end
            S_DIV: begin
                if (!sub_borrow) begin
                    rem_next = sub_res[REM_W-1:0];
                end
                q_next = {q_reg[QUO_BITS-3:0], !sub_borrow};
                if (step_reg == '0) begin
                    frac_next  = {q_reg, !sub_borrow};
                    state_next = S_OUT;
                end else begin
                    step_next = step_reg - 3'd1;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, temp_calc};
                    m_tuser_next  = flag_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and registers with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            base_reg     <= BASE_RESET;
            low_reg      <= LOW_RESET;
            high_reg     <= HIGH_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            base_reg     <= base_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        code_reg    <= code_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        probe_reg   <= probe_next;
        eq_reg      <= eq_next;
        gt_reg      <= gt_next;
        entry_reg   <= entry_next;
        below_reg   <= below_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        step_reg    <= step_next;
        deg_reg     <= deg_next;
        frac_reg    <= frac_next;
        flag_reg    <= flag_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // a convert word closes the input side on the next cycle
    a_convert_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == MODE_CONVERT)) |=> !s_tready)
        else $error("input not held off after convert word");

    // the flag code for an unused combination never leaves the block
    a_flag_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == LIMIT_NONE || m_tuser == LIMIT_LOW
                      || m_tuser == LIMIT_HIGH))
        else $error("bad limit flag");

    // interpolation only divides by a nonzero code span
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (den_reg != '0))
        else $error("zero divisor in interpolation");

    // a new result only appears out of the output state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside output state");
`endif

endmodule
